@@ rtl/core/qltx_pkg.sv @@
// Shared types, constants and codes for the four-lane UART transmitter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package qltx_pkg;

  // Default geometry, handed to the top level parameters
  localparam int LANES_DEF     = 4;
  localparam int DATA_BITS_DEF = 8;

  // Fixed field widths of the channel payloads
  localparam int IN_LANES   = 4;  // lanes that carry an input byte
  localparam int OUT_LANES  = 4;  // lanes visible in line_levels
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd2;

  // Parity modes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  // Reset value of the stop count register
  localparam logic [1:0] STOP_RESET = 2'd1;

  // Item actions
  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // What the line register takes on a beat
  localparam logic [2:0] DRV_HOLD   = 3'd0;
  localparam logic [2:0] DRV_START  = 3'd1;
  localparam logic [2:0] DRV_DATA   = 3'd2;
  localparam logic [2:0] DRV_PARITY = 3'd3;
  localparam logic [2:0] DRV_IDLE   = 3'd4;

  // Control from the sequencer to the lane datapath
  typedef struct packed {
    logic       load;    // capture new bytes and their parity
    logic       shift;   // step the data shifters one bit
    logic [2:0] drive;   // line register source
    logic       invert;  // line inversion
    logic       odd;     // odd parity selected
  } lane_ctl_t;

endpackage

@@ rtl/core/qltx_if.sv @@
// Valid/ready channel interfaces for the item and result beats.
// Depends on qltx_pkg for the payload widths.
`timescale 1ns / 1ps

interface qltx_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [qltx_pkg::BYTE_W-1:0]   byte_lane0;
  logic [qltx_pkg::BYTE_W-1:0]   byte_lane1;
  logic [qltx_pkg::BYTE_W-1:0]   byte_lane2;
  logic [qltx_pkg::BYTE_W-1:0]   byte_lane3;

  modport source (output valid, action, byte_lane0, byte_lane1, byte_lane2, byte_lane3,
                  input ready);
  modport sink   (input valid, action, byte_lane0, byte_lane1, byte_lane2, byte_lane3,
                  output ready);
endinterface

interface qltx_out_if;
  logic                             valid;
  logic                             ready;
  logic [qltx_pkg::OUT_LANES-1:0]   line_levels;
  logic                             busy_res;
  logic                             accepted;
  logic                             frame_end;

  modport source (output valid, line_levels, busy_res, accepted, frame_end,
                  input ready);
  modport sink   (input valid, line_levels, busy_res, accepted, frame_end,
                  output ready);
endinterface

@@ rtl/core/qltx_ctrl.sv @@
// Frame sequencer: configuration registers, bit phase and pending flag.
// Depends on qltx_pkg; drives the lane datapath through lane_ctl_t.
`timescale 1ns / 1ps

module qltx_ctrl #(
  parameter int DATA_BITS = qltx_pkg::DATA_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [qltx_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [qltx_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                              beat,
  input  logic                              action,
  output qltx_pkg::lane_ctl_t               lane_ctl,
  output logic                              busy_next,
  output logic                              accepted,
  output logic                              frame_end
);

  // start, data bits, parity, two stop periods at most
  localparam int PH_W = $clog2(DATA_BITS + 5);

  logic [1:0]      parity_mode;
  logic [1:0]      stop_count;
  logic            invert_lines;
  logic [PH_W-1:0] phase;
  logic [PH_W-1:0] phase_next;
  logic            pending;
  logic            pending_next;

  logic            par_on;
  logic [PH_W-1:0] stop_begin;
  logic [PH_W-1:0] stop_last;
  logic            idle;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_mode  <= qltx_pkg::PAR_NONE;
      stop_count   <= qltx_pkg::STOP_RESET;
      invert_lines <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        qltx_pkg::REG_PARITY: parity_mode  <= wr_data;
        qltx_pkg::REG_STOP:   stop_count   <= wr_data;
        qltx_pkg::REG_INVERT: invert_lines <= wr_data[0];
        default: ;
      endcase
    end
  end

  // frame layout
  assign par_on     = (parity_mode == qltx_pkg::PAR_EVEN) ||
                      (parity_mode == qltx_pkg::PAR_ODD);
  assign stop_begin = PH_W'(DATA_BITS + 1) + PH_W'(par_on);
  assign stop_last  = stop_begin + ((stop_count >= 2'd2) ? PH_W'(2) : PH_W'(1));
  assign idle       = !pending && (phase == '0);

  // sequencing of one beat
  always_comb begin
    phase_next      = phase;
    pending_next    = pending;
    lane_ctl        = '0;
    lane_ctl.drive  = qltx_pkg::DRV_HOLD;
    lane_ctl.invert = invert_lines;
    lane_ctl.odd    = (parity_mode == qltx_pkg::PAR_ODD);
    accepted        = 1'b0;
    frame_end       = 1'b0;
    if (beat) begin
      if (action == qltx_pkg::ACT_SUBMIT) begin
        if (idle) begin
          lane_ctl.load = 1'b1;
          pending_next  = 1'b1;
          accepted      = 1'b1;
        end
      end else if (phase == '0) begin
        if (pending) begin
          pending_next   = 1'b0;
          lane_ctl.drive = qltx_pkg::DRV_START;
          phase_next     = PH_W'(1);
        end else begin
          lane_ctl.drive = qltx_pkg::DRV_IDLE;
        end
      end else if (phase <= PH_W'(DATA_BITS)) begin
        lane_ctl.drive = qltx_pkg::DRV_DATA;
        lane_ctl.shift = 1'b1;
        phase_next     = phase + PH_W'(1);
      end else if (phase < stop_begin) begin
        lane_ctl.drive = qltx_pkg::DRV_PARITY;
        phase_next     = phase + PH_W'(1);
      end else begin
        lane_ctl.drive = qltx_pkg::DRV_IDLE;
        if (phase >= stop_last) begin
          frame_end  = 1'b1;
          phase_next = '0;
        end else begin
          phase_next = phase + PH_W'(1);
        end
      end
    end
  end

  assign busy_next = pending_next || (phase_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      pending <= 1'b0;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

  // a loaded frame waits only while the phase rests at idle
  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    pending |-> (phase == '0))
    else $error("frame pending while a frame is in flight");

  // the last stop period returns the sequencer to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (phase == '0) && !pending)
    else $error("sequencer not idle after frame end");

  // a taken submit leaves a frame pending
  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    accepted |=> pending)
    else $error("submit taken but no frame pending");

  // phase never runs past the longest frame
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_W'(DATA_BITS + 4))
    else $error("bit phase out of range");

endmodule

@@ rtl/core/qltx_lanes.sv @@
// Per-lane datapath: data shifters, parity bits and the line register.
// Depends on qltx_pkg; controlled by qltx_ctrl through lane_ctl_t.
`timescale 1ns / 1ps

module qltx_lanes #(
  parameter int LANES     = qltx_pkg::LANES_DEF,
  parameter int DATA_BITS = qltx_pkg::DATA_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  qltx_pkg::lane_ctl_t                                    lane_ctl,
  input  logic [qltx_pkg::IN_LANES-1:0][qltx_pkg::BYTE_W-1:0]    bytes,
  output logic [qltx_pkg::OUT_LANES-1:0]                         line_levels_next
);

  logic [LANES-1:0][DATA_BITS-1:0] shifter;
  logic [LANES-1:0]                parity;
  logic [LANES-1:0]                line_reg;
  logic [LANES-1:0]                line_next;

  // per lane: load, shift and line level selection
  for (genvar n = 0; n < LANES; n++) begin : g_lane
    logic [DATA_BITS-1:0] load_bits;

    if (n < qltx_pkg::IN_LANES) begin : g_byte
      assign load_bits = DATA_BITS'(bytes[n]);
    end else begin : g_none
      assign load_bits = '0;
    end

    always_ff @(posedge clk) begin
      if (lane_ctl.load) begin
        shifter[n] <= load_bits;
        parity[n]  <= (^load_bits) ^ lane_ctl.odd;
      end else if (lane_ctl.shift) begin
        shifter[n] <= shifter[n] >> 1;
      end
    end

    always_comb begin
      unique case (lane_ctl.drive)
        qltx_pkg::DRV_START:  line_next[n] = lane_ctl.invert;
        qltx_pkg::DRV_DATA:   line_next[n] = shifter[n][0] ^ lane_ctl.invert;
        qltx_pkg::DRV_PARITY: line_next[n] = parity[n] ^ lane_ctl.invert;
        qltx_pkg::DRV_IDLE:   line_next[n] = !lane_ctl.invert;
        default:              line_next[n] = line_reg[n];
      endcase
    end
  end

  // line register rests high out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      line_reg <= '1;
    end else begin
      line_reg <= line_next;
    end
  end

  // only the first four lanes are visible
  for (genvar k = 0; k < qltx_pkg::OUT_LANES; k++) begin : g_out
    if (k < LANES) begin : g_live
      assign line_levels_next[k] = line_next[k];
    end else begin : g_dead
      assign line_levels_next[k] = 1'b0;
    end
  end

endmodule

@@ rtl/core/quad_lane_uart_transmitter_unit.sv @@
// Top level of the four-lane UART transmitter: channels, result register.
// Depends on qltx_pkg, qltx_if, qltx_ctrl and qltx_lanes.
//
//   channel   dir  payload                                         beat when
//   item      in   action, byte_lane0..3                           valid & ready
//   result    out  line_levels, busy_res, accepted, frame_end      valid & ready
//   wr_*      in   wr_index, wr_data                               wr_en
//
// One item per cycle unless a full result register holds item.ready low; each item gives one result in the next cycle.
// The result register decouples the sides: item.ready is high whenever the
// result register is empty or being emptied in the same cycle.
// Synchronous reset: lines idle high, no frame, result register empty.
`timescale 1ns / 1ps

module quad_lane_uart_transmitter_unit #(
  parameter int LANES     = qltx_pkg::LANES_DEF,
  parameter int DATA_BITS = qltx_pkg::DATA_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [qltx_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [qltx_pkg::CFG_DATA_W-1:0]   wr_data,
  qltx_in_if.sink                           item,
  qltx_out_if.source                        result
);

  logic                                                  beat;
  logic                                                  res_valid;
  qltx_pkg::lane_ctl_t                                   lane_ctl;
  logic [qltx_pkg::IN_LANES-1:0][qltx_pkg::BYTE_W-1:0]   bytes;
  logic [qltx_pkg::OUT_LANES-1:0]                        line_levels_next;
  logic                                                  busy_next;
  logic                                                  accepted;
  logic                                                  frame_end;

  // handshake
  assign item.ready = !res_valid || result.ready;
  assign beat       = item.valid && item.ready;

  assign bytes[0] = item.byte_lane0;
  assign bytes[1] = item.byte_lane1;
  assign bytes[2] = item.byte_lane2;
  assign bytes[3] = item.byte_lane3;

  qltx_ctrl #(
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .beat      (beat),
    .action    (item.action),
    .lane_ctl  (lane_ctl),
    .busy_next (busy_next),
    .accepted  (accepted),
    .frame_end (frame_end)
  );

  qltx_lanes #(
    .LANES     (LANES),
    .DATA_BITS (DATA_BITS)
  ) u_lanes (
    .clk              (clk),
    .rst              (rst),
    .lane_ctl         (lane_ctl),
    .bytes            (bytes),
    .line_levels_next (line_levels_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (beat) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      result.line_levels <= line_levels_next;
      result.busy_res    <= busy_next;
      result.accepted    <= accepted;
      result.frame_end   <= frame_end;
    end
  end

  assign result.valid = res_valid;

  // every item beat fills the result register
  a_beat_fills: assert property (@(posedge clk) disable iff (rst)
    beat |=> res_valid)
    else $error("item beat did not produce a result");

  // a result that is not taken blocks further items
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(result.line_levels) || !item.valid || beat)
    else $error("result payload changed under stall");

  // a frame end always reports an idle block
  a_end_not_busy: assert property (@(posedge clk) disable iff (rst)
    (beat && frame_end) |=> !result.busy_res)
    else $error("frame end reported while busy");

endmodule

@@ verif/tb_quad_lane_uart_transmitter_unit.sv @@
// Self-checking testbench for the four-lane UART transmitter: directed frames, then
// random frames under several line settings, with random gaps on both channels.
// Depends on qltx_pkg, qltx_if and the RTL of quad_lane_uart_transmitter_unit.
`timescale 1ns / 1ps

// One result beat as seen on the output channel
typedef struct packed {
  logic [qltx_pkg::OUT_LANES-1:0] lines;
  logic                           busy;
  logic                           taken;
  logic                           frame_done;
} uart_result_t;

// Tracks the frame state of all lanes and holds the line levels still to arrive
class uart_frame_scoreboard;
  localparam int LANE_COUNT = qltx_pkg::OUT_LANES;
  localparam int DATA_BITS  = qltx_pkg::DATA_BITS_DEF;

  logic [qltx_pkg::BYTE_W-1:0] shift_reg [LANE_COUNT];
  logic                        par_bit   [LANE_COUNT];
  int unsigned                 phase;
  bit                          loaded;
  logic [LANE_COUNT-1:0]       lines;

  logic [1:0] parity_mode;
  logic [1:0] stop_count;
  logic       invert;

  uart_result_t levels_due[$];
  int unsigned  mismatches;

  function new();
    for (int n = 0; n < LANE_COUNT; n++) begin
      shift_reg[n] = '0;
      par_bit[n]   = 1'b0;
    end
    phase       = 0;
    loaded      = 1'b0;
    lines       = '1;
    parity_mode = qltx_pkg::PAR_NONE;
    stop_count  = qltx_pkg::STOP_RESET;
    invert      = 1'b0;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [1:0] val);
    case (idx)
      qltx_pkg::REG_PARITY: parity_mode = val;
      qltx_pkg::REG_STOP:   stop_count  = val;
      qltx_pkg::REG_INVERT: invert      = val[0];
      default: ;
    endcase
  endfunction

  function bit busy();
    return loaded || (phase != 0);
  endfunction

  function int unsigned outstanding();
    return levels_due.size();
  endfunction

  // Advance the lanes by one accepted item and queue the levels it must give
  function void note_item(logic act, logic [31:0] bytes);
    uart_result_t r;
    int unsigned  stop_begin;
    int unsigned  stop_len;
    r          = '0;
    stop_begin = DATA_BITS + 1 +
                 ((parity_mode == qltx_pkg::PAR_EVEN || parity_mode == qltx_pkg::PAR_ODD) ? 1 : 0);
    stop_len   = (stop_count >= 2) ? 2 : 1;

    if (act == qltx_pkg::ACT_SUBMIT) begin
      // taken only with no frame loaded and none on the lines
      if (!busy()) begin
        for (int n = 0; n < LANE_COUNT; n++) begin
          shift_reg[n] = bytes[8*n +: 8];
          par_bit[n]   = (^bytes[8*n +: 8]) ^ (parity_mode == qltx_pkg::PAR_ODD);
        end
        loaded  = 1'b1;
        r.taken = 1'b1;
      end
    end else if (phase == 0) begin
      if (loaded) begin
        loaded = 1'b0;
        lines  = {LANE_COUNT{invert}};  // start bit
        phase  = 1;
      end else begin
        lines = {LANE_COUNT{~invert}};  // idle follows the current inversion
      end
    end else if (phase <= DATA_BITS) begin
      for (int n = 0; n < LANE_COUNT; n++) begin
        lines[n]     = shift_reg[n][0] ^ invert;
        shift_reg[n] = shift_reg[n] >> 1;
      end
      phase++;
    end else if (phase < stop_begin) begin
      // parity goes out inverted along with everything else
      for (int n = 0; n < LANE_COUNT; n++)
        lines[n] = par_bit[n] ^ invert;
      phase++;
    end else begin
      lines = {LANE_COUNT{~invert}};
      if (phase - stop_begin >= stop_len) begin
        r.frame_done = 1'b1;
        phase        = 0;
      end else begin
        phase++;
      end
    end

    r.lines = lines;
    r.busy  = busy();
    levels_due.push_back(r);
  endfunction

  function void check_result(uart_result_t got);
    uart_result_t want;
    if (levels_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with nothing due: lines %h busy %b acc %b end %b",
                 $realtime, got.lines, got.busy, got.taken, got.frame_done);
      return;
    end
    want = levels_due.pop_front();
    if (got.lines !== want.lines || got.busy !== want.busy ||
        got.taken !== want.taken || got.frame_done !== want.frame_done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp lines %h busy %b acc %b end %b, got %h %b %b %b",
                 $realtime, want.lines, want.busy, want.taken, want.frame_done,
                 got.lines, got.busy, got.taken, got.frame_done);
    end
  endfunction
endclass

module tb_quad_lane_uart_transmitter_unit;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 150;
  localparam logic [1:0]  PAR_RESERVED = 2'd3;  // behaves as no parity

  logic clk;
  logic rst;
  logic wr_en;
  logic [qltx_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [qltx_pkg::CFG_DATA_W-1:0] wr_data;

  qltx_in_if  item_ch();
  qltx_out_if result_ch();

  quad_lane_uart_transmitter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  uart_frame_scoreboard sb;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned rx_stall   = 0;
  bit          tx_burst   = 1'b0;
  bit          rx_burst   = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, with stretches of none
  initial begin
    uart_result_t got;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= (rx_stall == 0);
      if (rx_stall != 0) rx_stall--;
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.lines      = result_ch.line_levels;
        got.busy       = result_ch.busy_res;
        got.taken      = result_ch.accepted;
        got.frame_done = result_ch.frame_end;
        sb.check_result(got);
        rx_stall = rx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 60) == 0) rx_burst = !rx_burst;
      end
    end
  end

  // Bytes with the all-zero and all-one cases coming up often
  function automatic logic [31:0] pick_bytes();
    logic [31:0] b;
    for (int n = 0; n < 4; n++)
      case ($urandom_range(0, 7))
        0:       b[8*n +: 8] = 8'h00;
        1:       b[8*n +: 8] = 8'hFF;
        default: b[8*n +: 8] = 8'($urandom);
      endcase
    return b;
  endfunction

  // Present one item after a random gap; return once its beat is taken
  task automatic send_item(input logic act, input logic [31:0] bytes);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 60) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.byte_lane0 <= bytes[7:0];
    item_ch.byte_lane1 <= bytes[15:8];
    item_ch.byte_lane2 <= bytes[23:16];
    item_ch.byte_lane3 <= bytes[31:24];
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(act, bytes);
    items_sent++;
  endtask

  // Sender drops valid and holds off until every result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] pm, input logic [1:0] sc, input logic inv);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= qltx_pkg::REG_PARITY;
    wr_data  <= pm;
    sb.write_reg(qltx_pkg::REG_PARITY, pm);
    @(negedge clk);
    wr_index <= qltx_pkg::REG_STOP;
    wr_data  <= sc;
    sb.write_reg(qltx_pkg::REG_STOP, sc);
    @(negedge clk);
    wr_index <= qltx_pkg::REG_INVERT;
    wr_data  <= {1'b0, inv};
    sb.write_reg(qltx_pkg::REG_INVERT, {1'b0, inv});
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic finish_frame();
    while (sb.busy()) send_item(qltx_pkg::ACT_TICK, pick_bytes());
  endtask

  // Submit, then tick the frame out with the odd refused submit mixed in
  task automatic run_frame(input logic [31:0] bytes);
    send_item(qltx_pkg::ACT_SUBMIT, bytes);
    while (sb.busy()) begin
      if ($urandom_range(0, 11) == 0) send_item(qltx_pkg::ACT_SUBMIT, pick_bytes());
      else send_item(qltx_pkg::ACT_TICK, pick_bytes());
      if ($urandom_range(0, 199) == 0) hold_until_drained();
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_item($urandom_range(0, 1) ? qltx_pkg::ACT_TICK : qltx_pkg::ACT_SUBMIT,
                  pick_bytes());
      else
        run_frame(pick_bytes());
    end
    finish_frame();
    hold_until_drained();
  endtask

  // Main sequence
  initial begin
    logic [1:0] pm_tab  [5];
    logic [1:0] sc_tab  [5];
    logic       inv_tab [5];
    pm_tab  = '{qltx_pkg::PAR_EVEN, PAR_RESERVED, qltx_pkg::PAR_NONE, qltx_pkg::PAR_ODD,
                qltx_pkg::PAR_EVEN};
    sc_tab  = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd2};
    inv_tab = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = qltx_pkg::REG_PARITY;
    wr_data            = '0;
    item_ch.valid      = 1'b0;
    item_ch.action     = qltx_pkg::ACT_SUBMIT;
    item_ch.byte_lane0 = '0;
    item_ch.byte_lane1 = '0;
    item_ch.byte_lane2 = '0;
    item_ch.byte_lane3 = '0;
    sb = new();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, a frame of mixed extremes, refused submit
    send_item(qltx_pkg::ACT_TICK, 32'h0);
    send_item(qltx_pkg::ACT_SUBMIT, 32'h00FF_A55A);
    send_item(qltx_pkg::ACT_SUBMIT, 32'h1234_5678);
    finish_frame();
    hold_until_drained();

    // Odd parity, two stops, inverted lines: idle level flips on the next tick
    write_config(qltx_pkg::PAR_ODD, 2'd2, 1'b1);
    send_item(qltx_pkg::ACT_TICK, 32'h0);
    send_item(qltx_pkg::ACT_SUBMIT, 32'h7FFE_0180);
    finish_frame();
    hold_until_drained();

    // Random phases, the first few over the extremes of every register
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5)
        write_config(pm_tab[ph], sc_tab[ph], inv_tab[ph]);
      else
        write_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
      run_phase(PHASE_ITEMS);
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qltx_pkg.sv
rtl/core/qltx_if.sv
rtl/core/qltx_ctrl.sv
rtl/core/qltx_lanes.sv
rtl/core/quad_lane_uart_transmitter_unit.sv
verif/tb_quad_lane_uart_transmitter_unit.sv
